>>> rtl/rdc_pkg.sv
// Shared types, constants and the digit-to-ASCII function for the radix digit converter.
package rdc_pkg;

  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] RADIX_RESET = 6'd10;

  localparam logic [6:0] CHAR_ZERO   = 7'd48;
  localparam logic [6:0] CHAR_NINE   = 7'd57;
  localparam logic [6:0] CHAR_A      = 7'd65;
  localparam logic [6:0] CHAR_Z      = 7'd90;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_RUN,
    FR_PUSH
  } front_state_t;

  function automatic logic [6:0] rdc_digit_symbol(input logic [5:0] d);
    logic [6:0] sym;
    if (d < 6'd10) begin
      sym = CHAR_ZERO + {1'b0, d};
    end else begin
      sym = CHAR_A + {1'b0, d} - 7'd10;
    end
    return sym;
  endfunction

endpackage

>>> rtl/rdc_front.sv
// Front end: accept a value and shift its bits into base-N digit cells, MSB first.
module rdc_front import rdc_pkg::*; #(
  parameter int MAX_DIGITS = 32,
  parameter int VALUE_BITS = 31,
  localparam int CW = $clog2(MAX_DIGITS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [5:0]                   radix,
  input  logic                         value_valid,
  output logic                         value_stall,
  input  logic [VALUE_BITS-1:0]        value,
  output logic                         push_valid,
  input  logic                         push_stall,
  output logic [CW-1:0]                push_count,
  output logic [MAX_DIGITS-1:0][5:0]   push_cells
);

  localparam int BW = $clog2(VALUE_BITS + 1);

  front_state_t state, state_next;

  logic [VALUE_BITS-1:0]       shreg;
  logic [BW-1:0]               bits;
  logic [CW-1:0]               count;
  logic [MAX_DIGITS-1:0][5:0]  cells;
  logic [MAX_DIGITS-1:0][5:0]  cells_next;
  logic [MAX_DIGITS:0]         gen;
  logic [MAX_DIGITS:0]         prop;
  logic [MAX_DIGITS:0]         carry;
  logic                        accept;

  assign accept = value_valid && !value_stall;

  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: if (value_valid) state_next = FR_RUN;
      FR_RUN:  if (bits == BW'(1)) state_next = FR_PUSH;
      FR_PUSH: if (!push_stall) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    value_stall = 1'b1;
    push_valid  = 1'b0;
    case (state)
      FR_IDLE: value_stall = 1'b0;
      FR_RUN:  value_stall = 1'b1;
      FR_PUSH: push_valid  = 1'b1;
      default: value_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // carry into each cell, resolved as one add over generate/propagate
  always_comb begin
    gen  = '0;
    prop = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      gen[i]  = ({cells[i], 1'b0} >= {1'b0, radix});
      prop[i] = ({cells[i], 1'b1} >= {1'b0, radix});
    end
    carry = (prop + gen + {{MAX_DIGITS{1'b0}}, shreg[VALUE_BITS-1]}) ^ prop ^ gen;
  end

  always_comb begin
    logic [6:0] v;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      v = {cells[i], carry[i]};
      if (v >= {1'b0, radix}) begin
        cells_next[i] = 6'(v - {1'b0, radix});
      end else begin
        cells_next[i] = v[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg <= value;
      bits  <= BW'(VALUE_BITS);
      count <= CW'(1);
      cells <= '0;
    end else if (state == FR_RUN) begin
      shreg <= shreg << 1;
      bits  <= bits - BW'(1);
      cells <= cells_next;
      if (count != CW'(MAX_DIGITS) && carry[count]) begin
        count <= count + CW'(1);
      end
    end
  end

  assign push_count = count;
  assign push_cells = cells;

endmodule

>>> rtl/rdc_queue.sv
// Two-entry queue between the front and back ends.
module rdc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign in_stall  = (fill == 2'd2);
  assign out_valid = (fill != 2'd0);
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

endmodule

>>> rtl/rdc_back.sv
// Back end: emit the digits of one conversion, most significant first, through an output register.
module rdc_back import rdc_pkg::*; #(
  parameter int MAX_DIGITS = 32,
  localparam int CW = $clog2(MAX_DIGITS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_stall,
  input  logic [CW-1:0]               q_count,
  input  logic [MAX_DIGITS-1:0][5:0]  q_cells,
  output logic                        digit_valid,
  input  logic                        digit_stall,
  output logic [6:0]                  digit_char,
  output logic                        last_digit
);

  localparam int PW = $clog2(MAX_DIGITS);

  logic                        busy;
  logic [PW-1:0]               pos;
  logic [MAX_DIGITS-1:0][5:0]  cells;
  logic                        load;
  logic                        emit;

  assign q_stall = busy;
  assign load    = q_valid && !busy;
  assign emit    = busy && (!digit_valid || !digit_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      digit_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (emit && pos == '0) begin
        busy <= 1'b0;
      end
      if (emit) begin
        digit_valid <= 1'b1;
      end else if (!digit_stall) begin
        digit_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cells <= q_cells;
      pos   <= PW'(q_count - CW'(1));
    end else if (emit) begin
      pos <= pos - PW'(1);
    end
    if (emit) begin
      digit_char <= rdc_digit_symbol(cells[pos]);
      last_digit <= (pos == '0);
    end
  end

endmodule

>>> rtl/radix_digit_converter_unit.sv
// Top level of the radix digit converter: base register, front end, queue and back end.
// Front end holds one value through its run and push states, one bit into the digit cells per cycle.
// Back end emits one digit per cycle at the output register while the output is not stalled.
// Front and back end each finish one value before taking the next; the queue holds two.
// Synchronous reset clears control state and sets the base to 10; no clearing pass.
module radix_digit_converter_unit import rdc_pkg::*; #(
  parameter int MAX_DIGITS = 32,
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [5:0]            cfg_wr_data,
  input  logic                  value_valid,
  output logic                  value_stall,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  digit_valid,
  input  logic                  digit_stall,
  output logic [6:0]            digit_char,
  output logic                  last_digit
);

  localparam int CW    = $clog2(MAX_DIGITS + 1);
  localparam int REC_W = CW + MAX_DIGITS * 6;

  logic [5:0]                 radix;
  logic                       push_valid;
  logic                       push_stall;
  logic [CW-1:0]              push_count;
  logic [MAX_DIGITS-1:0][5:0] push_cells;
  logic                       q_valid;
  logic                       q_stall;
  logic [REC_W-1:0]           q_data;
  logic [CW-1:0]              q_count;
  logic [MAX_DIGITS-1:0][5:0] q_cells;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_wr_data < RADIX_MIN) begin
        radix <= RADIX_MIN;
      end else if (cfg_wr_data > RADIX_MAX) begin
        radix <= RADIX_MAX;
      end else begin
        radix <= cfg_wr_data;
      end
    end
  end

  rdc_front #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .radix       (radix),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .push_valid  (push_valid),
    .push_stall  (push_stall),
    .push_count  (push_count),
    .push_cells  (push_cells)
  );

  rdc_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_stall  (push_stall),
    .in_data   ({push_count, push_cells}),
    .out_valid (q_valid),
    .out_stall (q_stall),
    .out_data  (q_data)
  );

  assign q_count = q_data[REC_W-1 -: CW];
  assign q_cells = q_data[MAX_DIGITS*6-1:0];

  rdc_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_stall     (q_stall),
    .q_count     (q_count),
    .q_cells     (q_cells),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .digit_char  (digit_char),
    .last_digit  (last_digit)
  );

endmodule

>>> rtl/rdc_checker.sv
// Port-level assertions for the radix digit converter, bound to the top level.
module rdc_checker import rdc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       value_valid,
  input logic       value_stall,
  input logic       digit_valid,
  input logic       digit_stall,
  input logic [6:0] digit_char,
  input logic       last_digit
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    digit_valid && digit_stall |=> digit_valid && $stable(digit_char) && $stable(last_digit))
    else $error("stalled digit transfer changed");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> (digit_char >= CHAR_ZERO && digit_char <= CHAR_NINE) ||
                    (digit_char >= CHAR_A && digit_char <= CHAR_Z))
    else $error("digit symbol outside 0-9 and A-Z");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !digit_valid && !value_stall)
    else $error("output valid or input stalled after reset");

  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    value_valid && !value_stall |=> value_stall)
    else $error("front end took a second value while converting");

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (.*);

>>> verif/radix_digit_converter_checker.sv
// Checker for the radix digit converter: predicts the digit stream and compares each transfer.
module radix_digit_converter_checker import rdc_pkg::*; #(
  parameter int MAX_DIGITS = 32,
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [5:0]            cfg_wr_data,
  input  logic                  value_valid,
  input  logic                  value_stall,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  digit_valid,
  input  logic                  digit_stall,
  input  logic [6:0]            digit_char,
  input  logic                  last_digit,
  output int                    fail_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [6:0] sym;
    logic       last;
  } digit_t;

  digit_t     pending_digits[$];
  logic [5:0] base_copy;

  function automatic logic [5:0] clamp_radix(input logic [5:0] d);
    if (d < RADIX_MIN) begin
      return RADIX_MIN;
    end else if (d > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return d;
  endfunction

  function automatic logic [6:0] symbol_of(input logic [5:0] d);
    if (d < 6'd10) begin
      return CHAR_ZERO + 7'(d);
    end
    return CHAR_A + 7'(d) - 7'd10;
  endfunction

  task automatic predict_digits(input logic [VALUE_BITS-1:0] v, input logic [5:0] b);
    logic [5:0]  cells[MAX_DIGITS];
    logic [63:0] num;
    int          n;
    digit_t      e;
    num = 64'(v);
    n = 0;
    if (num == 0) begin
      cells[0] = 6'd0;
      n = 1;
    end else begin
      while (num != 0 && n < MAX_DIGITS) begin
        cells[n] = 6'(num % 64'(b));
        num = num / 64'(b);
        n++;
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      e.sym = symbol_of(cells[k]);
      e.last = (k == 0);
      pending_digits.push_back(e);
    end
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    base_copy = RADIX_RESET;
  end

  always @(posedge clk) begin
    digit_t e;
    if (rst) begin
      pending_digits.delete();
      base_copy = RADIX_RESET;
    end else begin
      if (digit_valid && !digit_stall) begin
        if (pending_digits.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("digit check: unexpected transfer char %0d last %0d", digit_char,
                     last_digit);
          end
          fail_count++;
        end else begin
          e = pending_digits.pop_front();
          if (digit_char !== e.sym || last_digit !== e.last) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("digit check: expected char %0d last %0d, got char %0d last %0d",
                       e.sym, e.last, digit_char, last_digit);
            end
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) begin
        base_copy = clamp_radix(cfg_wr_data);
      end
      if (value_valid && !value_stall) begin
        predict_digits(value, base_copy);
      end
    end
    pending_count = pending_digits.size();
  end

endmodule

>>> verif/radix_digit_converter_unit_tb.sv
// Testbench top for the radix digit converter: stimulus, handshake pacing and verdict.
module radix_digit_converter_unit_tb import rdc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIGITS      = 32;
  localparam int VALUE_BITS      = 31;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int HOLD_AT         = 600;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int END_CYCLES      = 40;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [5:0]            cfg_wr_data;
  logic                  value_valid;
  logic                  value_stall;
  logic [VALUE_BITS-1:0] value;
  logic                  digit_valid;
  logic                  digit_stall;
  logic [6:0]            digit_char;
  logic                  last_digit;

  int                    fail_count;
  int                    pending_count;
  int                    idle_cycles;
  logic                  sender_quiet;
  logic                  receiver_quiet;
  logic [VALUE_BITS-1:0] send_q[$];

  radix_digit_converter_unit #(
    .MAX_DIGITS(MAX_DIGITS),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .value(value),
    .digit_valid(digit_valid),
    .digit_stall(digit_stall),
    .digit_char(digit_char),
    .last_digit(last_digit)
  );

  radix_digit_converter_checker #(
    .MAX_DIGITS(MAX_DIGITS),
    .VALUE_BITS(VALUE_BITS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .value(value),
    .digit_valid(digit_valid),
    .digit_stall(digit_stall),
    .digit_char(digit_char),
    .last_digit(last_digit),
    .fail_count(fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [VALUE_BITS-1:0] pick_value(input logic [5:0] setting);
    logic [63:0] p;
    logic [63:0] b;
    int          k;
    logic [VALUE_BITS-1:0] v;
    b = (setting < RADIX_MIN) ? 64'(RADIX_MIN) :
        (setting > RADIX_MAX) ? 64'(RADIX_MAX) : 64'(setting);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = VALUE_BITS'($urandom);
      4: v = VALUE_BITS'($urandom_range(0, 2000));
      5: v = VALUE_BITS'($urandom >> $urandom_range(1, 31));
      6: v = $urandom_range(0, 1) ? '1 : '0;
      default: begin
        p = 1;
        k = $urandom_range(1, 31);
        while (k > 0 && p * b <= 64'h7FFF_FFFF) begin
          p = p * b;
          k--;
        end
        v = VALUE_BITS'(p - 64'($urandom_range(0, 1)));
      end
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (send_q.size() != 0 || value_valid || pending_count != 0);
  endtask

  task automatic write_radix(input logic [5:0] d);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // sender: hold payload while stalled, draw a gap after each transfer
  initial begin
    int gap_cnt;
    value_valid = 1'b0;
    value = '0;
    gap_cnt = 0;
    forever begin
      @(posedge clk);
      if (!(value_valid && value_stall)) begin
        if (value_valid) begin
          gap_cnt = sender_quiet ? 0 : $urandom_range(0, 8);
        end
        if (gap_cnt > 0) begin
          gap_cnt--;
          value_valid <= 1'b0;
        end else if (send_q.size() > 0) begin
          value <= send_q.pop_front();
          value_valid <= 1'b1;
        end else begin
          value_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: draw a stall count per transfer, one long hold-off to back up the block
  initial begin
    int wait_cnt;
    int digits_seen;
    digit_stall = 1'b0;
    wait_cnt = 0;
    digits_seen = 0;
    forever begin
      @(posedge clk);
      if (digit_valid && !digit_stall) begin
        digits_seen++;
        wait_cnt = receiver_quiet ? 0 : $urandom_range(0, 8);
        if (digits_seen == HOLD_AT) begin
          wait_cnt = HOLD_CYCLES;
        end
      end
      if (wait_cnt > 0) begin
        wait_cnt--;
        digit_stall <= 1'b1;
      end else begin
        digit_stall <= 1'b0;
      end
    end
  end

  initial begin
    idle_cycles = 0;
  end

  always @(posedge clk) begin
    if ((value_valid && !value_stall) || (digit_valid && !digit_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("radix_digit_converter_unit: mismatch");
    $finish;
  end

  initial begin
    logic [5:0] setting;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 6'd0;
    sender_quiet = 1'b0;
    receiver_quiet = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset base
    send_q.push_back(31'd0);
    send_q.push_back(31'd1);
    send_q.push_back(31'd9);
    send_q.push_back(31'd10);
    send_q.push_back(31'd100);
    send_q.push_back(31'h7FFF_FFFF);
    send_q.push_back(31'h4000_0000);
    send_q.push_back(31'd123456789);

    write_radix(RADIX_MIN);
    send_q.push_back(31'd0);
    send_q.push_back(31'd1);
    send_q.push_back(31'h7FFF_FFFF);
    send_q.push_back(31'h2AAA_AAAA);
    send_q.push_back(31'h5555_5555);

    write_radix(RADIX_MAX);
    send_q.push_back(31'd0);
    send_q.push_back(31'd35);
    send_q.push_back(31'd36);
    send_q.push_back(31'd60466175);
    send_q.push_back(31'h7FFF_FFFF);

    // clamp below and above the legal range
    write_radix(6'd0);
    send_q.push_back(31'd6);
    send_q.push_back(31'h7FFF_FFFF);
    write_radix(6'd63);
    send_q.push_back(31'd35);
    send_q.push_back(31'h7FFF_FFFF);
    write_radix(6'd1);
    send_q.push_back(31'd5);
    write_radix(6'd37);
    send_q.push_back(31'd1296);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: setting = 6'd16;
        1: setting = 6'd3;
        2: setting = 6'd35;
        3: setting = 6'd7;
        default: setting = 6'($urandom_range(0, 63));
      endcase
      write_radix(setting);
      sender_quiet = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      repeat (ITEMS_PER_PHASE) send_q.push_back(pick_value(setting));
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("radix_digit_converter_unit: match");
    end else begin
      $display("radix_digit_converter_unit: mismatch");
    end
    $finish;
  end

endmodule
